// File: sv/hkst_pkg.sv
// Shared types, constants and the key table for the HID key to serial keyboard transmitter.
// No dependencies; used by every module of the block.
package hkst_pkg;

   localparam int CODE_BITS = 8;
   localparam int BIT_W     = $clog2(CODE_BITS);

   // HID usage codes
   localparam logic [7:0] USAGE_FIRST  = 8'h04;
   localparam logic [7:0] USAGE_LAST   = 8'h38;
   localparam logic [7:0] USAGE_DIGIT6 = 8'h23;
   localparam logic [7:0] USAGE_DIGIT7 = 8'h24;
   localparam logic [7:0] USAGE_DIGIT8 = 8'h25;
   localparam logic [7:0] USAGE_DIGIT9 = 8'h26;
   localparam logic [7:0] USAGE_DIGIT0 = 8'h27;
   localparam logic [7:0] USAGE_CAPS   = 8'h39;
   localparam logic [7:0] USAGE_DEL    = 8'h4C;
   localparam logic [7:0] USAGE_END    = 8'h4D;
   localparam logic [7:0] USAGE_RIGHT  = 8'h4F;
   localparam logic [7:0] USAGE_LEFT   = 8'h50;
   localparam logic [7:0] USAGE_DOWN   = 8'h51;
   localparam logic [7:0] USAGE_UP     = 8'h52;

   // modifier masks
   localparam logic [7:0] MOD_CTRL  = 8'h11;
   localparam logic [7:0] MOD_SHIFT = 8'h22;

   // terminal codes
   localparam logic [CODE_BITS-1:0] NO_CODE    = 8'h03;
   localparam logic [CODE_BITS-1:0] CODE_DEL   = 8'h3f;
   localparam logic [CODE_BITS-1:0] CODE_RIGHT = 8'h0d;
   localparam logic [CODE_BITS-1:0] CODE_LEFT  = 8'h0c;
   localparam logic [CODE_BITS-1:0] CODE_DOWN  = 8'h0f;
   localparam logic [CODE_BITS-1:0] CODE_UP    = 8'h0e;
   localparam logic [CODE_BITS-1:0] CODE_END   = 8'h02;
   localparam logic [CODE_BITS-1:0] CODE_CAPS  = 8'h07;
   localparam logic [CODE_BITS-1:0] CODE_SH6   = 8'h10;
   localparam logic [CODE_BITS-1:0] CODE_SH7   = 8'h16;
   localparam logic [CODE_BITS-1:0] CODE_SH8   = 8'h17;
   localparam logic [CODE_BITS-1:0] CODE_SH9   = 8'h18;
   localparam logic [CODE_BITS-1:0] CODE_SH0   = 8'h19;
   localparam logic [CODE_BITS-1:0] FLAG_UNSHIFTED = 8'h80;
   localparam logic [CODE_BITS-1:0] FLAG_CTRL      = 8'h40;

   localparam int TABLE_DEPTH = 53;
   localparam int TABLE_IDX_W = $clog2(TABLE_DEPTH);

   localparam logic [CODE_BITS-1:0] KEY_TABLE [TABLE_DEPTH] = '{
      8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c,
      8'h2d, 8'h2e, 8'h2f, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
      8'h39, 8'h3a,
      8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h10,
      8'h05, 8'h0b, 8'h00, 8'h01, 8'h08, 8'h3e, 8'h1d,
      8'h3b, 8'h3d, 8'h3c, 8'h03, 8'h1b, 8'h1a,
      8'h20, 8'h1c, 8'h1e, 8'h1f
   };

   typedef enum logic [2:0] {
      ST_STARTED  = 3'd0,
      ST_KEY_UP   = 3'd1,
      ST_UNMAPPED = 3'd2,
      ST_CTRL_DEL = 3'd3,
      ST_DROPPED  = 3'd4,
      ST_SAMPLE   = 3'd5
   } status_type;

   // one step of the transmitter
   typedef struct packed {
      logic                 step;    // an item is applied this cycle
      logic                 sample;  // item is a clock pin sample
      logic                 level;   // sampled clock level
      logic                 load;    // start sending code
      logic [CODE_BITS-1:0] code;
   } tx_ctrl_type;

   typedef struct packed {
      logic busy;       // before this item
      logic line_next;  // data line after this item
      logic busy_next;  // busy after this item
   } tx_stat_type;

endpackage

// File: sv/hkst_key_map.sv
// HID usage plus modifier byte to terminal code mapping, pure logic.
// Depends on hkst_pkg for the key table and code constants.
module hkst_key_map
   import hkst_pkg::*;
(
   input  logic [7:0]           key_code,
   input  logic [7:0]           modifiers,
   output logic [CODE_BITS-1:0] code,
   output logic                 mapped
);

   logic [CODE_BITS-1:0]   base;
   logic [CODE_BITS-1:0]   shifted;
   logic [7:0]             offset;
   logic [TABLE_IDX_W-1:0] idx;
   logic                   shift_held;
   logic                   ctrl_held;

   assign offset     = key_code - USAGE_FIRST;
   assign idx        = offset[TABLE_IDX_W-1:0];
   assign shift_held = |(modifiers & MOD_SHIFT);
   assign ctrl_held  = |(modifiers & MOD_CTRL);

   always_comb begin
      if (key_code >= USAGE_FIRST && key_code <= USAGE_LAST) begin
         base = KEY_TABLE[idx];
      end else begin
         unique case (key_code)
            USAGE_DEL:   base = CODE_DEL;
            USAGE_RIGHT: base = CODE_RIGHT;
            USAGE_LEFT:  base = CODE_LEFT;
            USAGE_DOWN:  base = CODE_DOWN;
            USAGE_UP:    base = CODE_UP;
            USAGE_END:   base = CODE_END;
            USAGE_CAPS:  base = CODE_CAPS;
            default:     base = NO_CODE;
         endcase
      end
   end

   // table entry equal to the no-code marker counts as unmappable too
   assign mapped = (base != NO_CODE);

   always_comb begin
      if (!shift_held) begin
         shifted = base | FLAG_UNSHIFTED;
      end else begin
         unique case (key_code)
            USAGE_DIGIT6: shifted = CODE_SH6;
            USAGE_DIGIT7: shifted = CODE_SH7;
            USAGE_DIGIT8: shifted = CODE_SH8;
            USAGE_DIGIT9: shifted = CODE_SH9;
            USAGE_DIGIT0: shifted = CODE_SH0;
            default:      shifted = base;
         endcase
      end
      code = ctrl_held ? (shifted | FLAG_CTRL) : shifted;
   end

endmodule

// File: sv/hkst_tx.sv
// Serial transmitter: shift register, bit counter and clock phase tracking.
// Depends on hkst_pkg for the control and status structs.
module hkst_tx
   import hkst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  tx_ctrl_type ctrl,
   output tx_stat_type stat
);

   typedef enum logic [1:0] {
      PH_IDLE      = 2'd0,
      PH_WAIT_LOW  = 2'd1,
      PH_WAIT_HIGH = 2'd2,
      PH_FINAL     = 2'd3
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [BIT_W-1:0]     bit_pos_ff, bit_pos_in;
   logic [CODE_BITS-1:0] shift_ff, shift_in;
   logic                 line_ff, line_in;

   always_comb begin
      phase_in   = phase_ff;
      bit_pos_in = bit_pos_ff;
      shift_in   = shift_ff;
      line_in    = line_ff;
      if (ctrl.step && ctrl.sample) begin
         unique case (phase_ff)
            PH_WAIT_LOW: begin
               if (!ctrl.level) begin
                  line_in  = ~shift_ff[bit_pos_ff];
                  phase_in = PH_WAIT_HIGH;
               end
            end
            PH_WAIT_HIGH: begin
               if (ctrl.level) begin
                  phase_in   = (bit_pos_ff == BIT_W'(CODE_BITS - 1)) ? PH_FINAL
                                                                     : PH_WAIT_LOW;
                  bit_pos_in = bit_pos_ff + 1'b1;
               end
            end
            PH_FINAL: begin
               if (!ctrl.level) begin
                  line_in  = 1'b0;
                  phase_in = PH_IDLE;
               end
            end
            PH_IDLE: ;
         endcase
      end else if (ctrl.step && ctrl.load) begin
         shift_in   = ctrl.code;
         bit_pos_in = '0;
         line_in    = 1'b1;
         phase_in   = PH_WAIT_LOW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         bit_pos_ff <= '0;
         shift_ff   <= '0;
         line_ff    <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         bit_pos_ff <= bit_pos_in;
         shift_ff   <= shift_in;
         line_ff    <= line_in;
      end
   end

   assign stat.busy      = (phase_ff != PH_IDLE);
   assign stat.line_next = line_in;
   assign stat.busy_next = (phase_in != PH_IDLE);

endmodule

// File: sv/hid_key_to_serial_keyboard_tx_core.sv
// Top level of the HID key to serial keyboard transmitter.
// Depends on hkst_pkg, hkst_key_map and hkst_tx.
//
// Use:
//   req channel carries one item per transfer: either a sample of the host
//   clock pin (req_tuser = 0) or a HID key event (req_tuser = 1). Clock
//   samples are expected every cycle; the pin level is tracked and the data
//   line is shifted one code bit per low clock phase, inverted, LSB first.
//   rsp channel returns exactly one result per request: data line level and
//   busy flag after the item, the code started (else 0) and a status code.
// Latency and throughput:
//   one transfer per cycle while rsp_tready allows; the result is registered and
//   offered on rsp in the cycle after the request transfer. Mapping and the
//   transmitter update are a single logic pass from request to result register.
// Stall:
//   req_tready follows the result register: while an unclaimed result sits
//   there and rsp_tready is low, no request is taken. Otherwise a new
//   request is taken in the same cycle the previous result leaves.
// Reset:
//   synchronous, active high; transmitter idle, line low, no result pending.
//   Key-downs that arrive while a code is being sent are dropped (status 4).
module hid_key_to_serial_keyboard_tx_core
   import hkst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] clock_level, [8:1] key_code, [9] key_down, [17:10] modifiers, [23:18] zero
   input  logic [23:0] req_tdata,
   // [0] kind
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] data_level, [1] busy_res, [9:2] code_sent, [12:10] event_status, [15:13] zero
   output logic [15:0] rsp_tdata
);

   logic                 req_accept;
   logic                 kind;
   logic                 clock_level;
   logic [7:0]           key_code;
   logic                 key_down;
   logic [7:0]           modifiers;

   logic [CODE_BITS-1:0] map_code;
   logic                 map_ok;
   logic                 ctrl_held;

   tx_ctrl_type          tx_ctrl;
   tx_stat_type          tx_stat;
   status_type           status;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 data_level_ff;
   logic                 busy_res_ff;
   logic [CODE_BITS-1:0] code_sent_ff;
   status_type           status_ff;

   // unpack request
   assign kind        = req_tuser;
   assign clock_level = req_tdata[0];
   assign key_code    = req_tdata[8:1];
   assign key_down    = req_tdata[9];
   assign modifiers   = req_tdata[17:10];
   assign ctrl_held   = |(modifiers & MOD_CTRL);

   // free when the result register is empty or being emptied
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   hkst_key_map u_key_map (
      .key_code  (key_code),
      .modifiers (modifiers),
      .code      (map_code),
      .mapped    (map_ok)
   );

   // key checks in order: key-up, ctrl+delete, unmappable, busy
   always_comb begin
      priority if (!kind) begin
         status = ST_SAMPLE;
      end else if (!key_down) begin
         status = ST_KEY_UP;
      end else if (ctrl_held && key_code == USAGE_DEL) begin
         status = ST_CTRL_DEL;
      end else if (!map_ok) begin
         status = ST_UNMAPPED;
      end else if (tx_stat.busy) begin
         status = ST_DROPPED;
      end else begin
         status = ST_STARTED;
      end
   end

   assign tx_ctrl.step   = req_accept;
   assign tx_ctrl.sample = !kind;
   assign tx_ctrl.level  = clock_level;
   assign tx_ctrl.load   = (status == ST_STARTED);
   assign tx_ctrl.code   = map_code;

   hkst_tx u_tx (
      .clock (clock),
      .reset (reset),
      .ctrl  (tx_ctrl),
      .stat  (tx_stat)
   );

   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded on each request transfer
   always_ff @(posedge clock) begin
      if (req_accept) begin
         data_level_ff <= tx_stat.line_next;
         busy_res_ff   <= tx_stat.busy_next;
         code_sent_ff  <= (status == ST_STARTED) ? map_code : '0;
         status_ff     <= status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, status_ff, code_sent_ff, busy_res_ff, data_level_ff};

   // a started send leaves the line high and the transmitter busy
   a_started_busy : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == ST_STARTED) |-> (busy_res_ff && data_level_ff))
      else $error("started send not reported busy with line high");

   // only a started send reports a code
   a_code_only_started : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff != ST_STARTED) |-> (code_sent_ff == '0))
      else $error("code reported for an event that started nothing");

   // a drop implies a send was in progress and still is
   a_drop_busy : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == ST_DROPPED) |-> busy_res_ff)
      else $error("event dropped while transmitter idle");

   // a pending unclaimed result blocks the next request
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_accept)
      else $error("request taken over a pending result");

endmodule

// File: verif/tb_hid_key_to_serial_keyboard_tx_core.sv
// Self-checking bench for hid_key_to_serial_keyboard_tx_core: key events and host clock samples
// go in on req, and each rsp transfer is checked against an in-bench transmitter model.
// Depends on hkst_pkg and the core RTL.
module tb_hid_key_to_serial_keyboard_tx_core;
   import hkst_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int  NUM_SENDS  = 7;       // random send sequences
   localparam int  IDLE_PCT   = 29;      // idle cycles per hundred on either side
   localparam int  QUIET_FROM = 400;     // cycle window with no idling at all
   localparam int  QUIET_TO   = 900;
   localparam int  DRAIN_CYC  = 5;       // result register latency plus margin
   localparam real RUN_LIMIT  = 2.0e6;   // ns

   typedef enum logic [1:0] {
      PH_IDLE      = 2'd0,
      PH_WAIT_LOW  = 2'd1,
      PH_WAIT_HIGH = 2'd2,
      PH_FINAL     = 2'd3
   } tx_phase_type;

   // one request transfer
   typedef struct packed {
      logic       kind;       // 0 clock sample, 1 key event
      logic       clk_level;
      logic [7:0] key_code;
      logic       key_down;
      logic [7:0] modifiers;
   } key_item_type;

   // one result transfer, lowest field last so it matches rsp_tdata[12:0]
   typedef struct packed {
      status_type           status;
      logic [CODE_BITS-1:0] code;
      logic                 busy;
      logic                 data_level;
   } line_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   key_item_type    pending_key_q[$];    // stimulus waiting to be driven
   line_result_type expected_line_q[$];  // predicted results, oldest first

   // transmitter model state
   tx_phase_type         tx_phase = PH_IDLE;
   logic [2:0]           tx_bit   = '0;
   logic [CODE_BITS-1:0] tx_byte  = '0;
   logic                 tx_line  = 1'b0;

   logic req_taken = 1'b0;   // req transfer at the last rising edge
   int   cycle_count = 0;
   int   errors = 0;

   hid_key_to_serial_keyboard_tx_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Model of the mapping and the serialiser
   // ---------------------------------------------------------------------

   // code before the shift and ctrl flags; NO_CODE when the usage has none
   function automatic logic [CODE_BITS-1:0] plain_code(input logic [7:0] key);
      if (key >= USAGE_FIRST && key <= USAGE_LAST)
         return KEY_TABLE[key - USAGE_FIRST];
      case (key)
         USAGE_DEL:   return CODE_DEL;
         USAGE_RIGHT: return CODE_RIGHT;
         USAGE_LEFT:  return CODE_LEFT;
         USAGE_DOWN:  return CODE_DOWN;
         USAGE_UP:    return CODE_UP;
         USAGE_END:   return CODE_END;
         USAGE_CAPS:  return CODE_CAPS;
         default:     return NO_CODE;
      endcase
   endfunction

   function automatic logic [CODE_BITS-1:0] terminal_code(input logic [7:0] key,
                                                          input logic [7:0] mods);
      logic [CODE_BITS-1:0] c;
      c = plain_code(key);
      if (c == NO_CODE)
         return NO_CODE;
      if ((mods & MOD_SHIFT) == 8'h00) begin
         c = c | FLAG_UNSHIFTED;
      end else begin
         // shifted top-row digits have their own codes
         case (key)
            USAGE_DIGIT6: c = CODE_SH6;
            USAGE_DIGIT7: c = CODE_SH7;
            USAGE_DIGIT8: c = CODE_SH8;
            USAGE_DIGIT9: c = CODE_SH9;
            USAGE_DIGIT0: c = CODE_SH0;
            default: ;
         endcase
      end
      if ((mods & MOD_CTRL) != 8'h00)
         c = c | FLAG_CTRL;
      return c;
   endfunction

   // one host clock pin sample against the serialiser state
   task automatic track_host_clock(input logic lvl);
      case (tx_phase)
         PH_WAIT_LOW: begin
            if (!lvl) begin
               tx_line  = ~tx_byte[tx_bit];
               tx_phase = PH_WAIT_HIGH;
            end
         end
         PH_WAIT_HIGH: begin
            if (lvl) begin
               tx_phase = (tx_bit == 3'(CODE_BITS - 1)) ? PH_FINAL : PH_WAIT_LOW;
               tx_bit   = tx_bit + 3'd1;
            end
         end
         PH_FINAL: begin
            if (!lvl) begin
               tx_line  = 1'b0;
               tx_phase = PH_IDLE;
            end
         end
         default: ;
      endcase
   endtask

   // advance the model by one accepted item and give the result it causes
   task automatic apply_key_item(input key_item_type it, output line_result_type r);
      logic [CODE_BITS-1:0] c;
      r.code = '0;
      if (!it.kind) begin
         track_host_clock(it.clk_level);
         r.status = ST_SAMPLE;
      end else if (!it.key_down) begin
         r.status = ST_KEY_UP;
      end else if ((it.modifiers & MOD_CTRL) != 8'h00 && it.key_code == USAGE_DEL) begin
         r.status = ST_CTRL_DEL;
      end else begin
         c = terminal_code(it.key_code, it.modifiers);
         if (c == NO_CODE) begin
            r.status = ST_UNMAPPED;
         end else if (tx_phase != PH_IDLE) begin
            r.status = ST_DROPPED;
         end else begin
            tx_byte  = c;
            tx_bit   = '0;
            tx_line  = 1'b1;
            tx_phase = PH_WAIT_LOW;
            r.code   = c;
            r.status = ST_STARTED;
         end
      end
      r.data_level = tx_line;
      r.busy       = (tx_phase != PH_IDLE);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus builders
   // ---------------------------------------------------------------------

   // key event; the clock level bit is don't-care, so randomise it
   task automatic queue_key(input logic [7:0] key, input logic down, input logic [7:0] mods);
      key_item_type it;
      it.kind      = 1'b1;
      it.clk_level = 1'($urandom_range(1));
      it.key_code  = key;
      it.key_down  = down;
      it.modifiers = mods;
      pending_key_q.push_back(it);
   endtask

   // clock pin sample; key fields are ignored by the block, randomise them
   task automatic queue_sample(input logic lvl);
      key_item_type it;
      it.kind      = 1'b0;
      it.clk_level = lvl;
      it.key_code  = 8'($urandom_range(255));
      it.key_down  = 1'($urandom_range(1));
      it.modifiers = 8'($urandom_range(255));
      pending_key_q.push_back(it);
   endtask

   // random key event, any field value
   task automatic queue_noise_key();
      queue_key(8'($urandom_range(255)), 1'($urandom_range(1)), 8'($urandom_range(255)));
   endtask

   // run of clock samples at one level, with the odd stray key event mixed in
   task automatic queue_clock_run(input logic lvl, input int len, input int noise_pct);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < noise_pct)
            queue_noise_key();
         queue_sample(lvl);
      end
   endtask

   // host clock for one code: a low and a high phase per bit, then the closing low.
   // A cut below CODE_BITS stops the waveform early so the next send finds it busy.
   task automatic queue_host_clock(input int max_run, input int noise_pct, input int cut);
      if (max_run > 1 && $urandom_range(3) == 0)
         queue_clock_run(1'b1, $urandom_range(1, max_run), noise_pct);
      for (int b = 0; b < cut; b++) begin
         queue_clock_run(1'b0, $urandom_range(1, max_run), noise_pct);
         queue_clock_run(1'b1, $urandom_range(1, max_run), noise_pct);
      end
      if (cut == CODE_BITS)
         queue_clock_run(1'b0, $urandom_range(1, max_run), noise_pct);
   endtask

   // a key-down that mostly maps: a random usage in range (one entry holds no code) or a fixed key
   function automatic logic [7:0] pick_mapped_usage();
      if ($urandom_range(3) != 0)
         return USAGE_FIRST + 8'($urandom_range(TABLE_DEPTH - 1));
      case ($urandom_range(6))
         0:       return USAGE_DEL;
         1:       return USAGE_END;
         2:       return USAGE_RIGHT;
         3:       return USAGE_LEFT;
         4:       return USAGE_DOWN;
         5:       return USAGE_UP;
         default: return USAGE_CAPS;
      endcase
   endfunction

   initial begin
      logic [7:0] mods;
      logic [7:0] key;

      // --- directed part ---
      // clock samples while idle change nothing
      queue_sample(1'b0);
      queue_sample(1'b1);
      // events that never start a send
      queue_key(USAGE_FIRST, 1'b0, 8'h00);      // key-up
      queue_key(USAGE_DEL, 1'b1, 8'h01);        // ctrl+delete, left ctrl
      queue_key(USAGE_DEL, 1'b1, 8'hF0);        // ctrl+delete, right ctrl
      queue_key(8'h00, 1'b1, 8'h00);            // no code
      queue_key(8'hFF, 1'b1, 8'hFF);            // no code, every modifier
      queue_key(8'h32, 1'b1, 8'h00);            // table entry that holds the no-code value

      // first usage, unshifted; key events during the transfer are dropped or ignored
      queue_key(USAGE_FIRST, 1'b1, 8'h00);
      queue_key(USAGE_LAST, 1'b1, 8'h00);       // dropped, busy
      queue_key(USAGE_LAST, 1'b0, 8'h00);       // key-up wins over busy
      queue_key(USAGE_DEL, 1'b1, 8'h10);        // ctrl+delete wins over busy
      queue_key(8'h00, 1'b1, 8'h00);            // no code wins over busy
      queue_host_clock(1, 0, CODE_BITS);
      // last usage with ctrl and shift
      queue_key(USAGE_LAST, 1'b1, 8'hFF);
      queue_host_clock(1, 0, CODE_BITS);
      // fixed keys
      queue_key(USAGE_DEL, 1'b1, 8'h00);
      queue_host_clock(1, 0, CODE_BITS);
      queue_key(USAGE_RIGHT, 1'b1, 8'h22);
      queue_host_clock(1, 0, CODE_BITS);
      queue_key(USAGE_UP, 1'b1, 8'h11);
      queue_host_clock(2, 0, CODE_BITS);
      // shifted digits, left and right shift
      queue_key(USAGE_DIGIT6, 1'b1, 8'h02);
      queue_host_clock(1, 0, CODE_BITS);
      queue_key(USAGE_DIGIT0, 1'b1, 8'h20);
      queue_host_clock(1, 0, CODE_BITS);
      queue_key(USAGE_CAPS, 1'b1, 8'h00);
      queue_host_clock(1, 0, CODE_BITS);

      // --- random part: mostly whole sends with random content ---
      for (int s = 0; s < NUM_SENDS; s++) begin
         // a few stray items before each send
         repeat ($urandom_range(3)) begin
            if ($urandom_range(1) == 0)
               queue_sample(1'($urandom_range(1)));
            else
               queue_noise_key();
         end
         mods = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255));
         if ($urandom_range(9) == 0) begin
            queue_noise_key();
         end else if ($urandom_range(7) == 0) begin
            key = USAGE_DIGIT6 + 8'($urandom_range(4));
            queue_key(key, 1'b1, mods | MOD_SHIFT);
         end else begin
            queue_key(pick_mapped_usage(), 1'b1, mods);
         end
         // one waveform in ten stops early
         queue_host_clock(3, 8,
                          ($urandom_range(9) == 0) ? $urandom_range(CODE_BITS - 1) : CODE_BITS);
      end
      // tidy finish: plenty of clock so any transfer in flight completes
      queue_host_clock(1, 0, CODE_BITS);
      queue_host_clock(1, 0, CODE_BITS);
   end

   // ---------------------------------------------------------------------
   // Reset, then wait for the stimulus to drain and judge the run
   // ---------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      while (pending_key_q.size() != 0 || req_tvalid || expected_line_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYC) @(negedge clock);
      if (expected_line_q.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $realtime,
                  expected_line_q.size());
         errors++;
      end
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #(RUN_LIMIT);
      $display("tb: failure");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Driver: inputs change on the falling edge only
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      key_item_type it;
      logic         quiet;
      quiet = (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO);
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         // hold the item until its transfer, then offer the next or idle
         if (!req_tvalid || req_taken) begin
            if (pending_key_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
               it = pending_key_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {6'b0, it.modifiers, it.key_down, it.key_code, it.clk_level};
               req_tuser  <= it.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: transfers are sampled on the rising edge
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      line_result_type want;
      line_result_type got;
      cycle_count <= cycle_count + 1;
      req_taken   <= !reset && req_tvalid && req_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = line_result_type'(rsp_tdata[12:0]);
         if (expected_line_q.size() == 0) begin
            $display("%0t: result with nothing expected, got line %b busy %b code %h status %0d",
                     $realtime, got.data_level, got.busy, got.code, got.status);
            errors++;
         end else begin
            want = expected_line_q.pop_front();
            if (got.data_level !== want.data_level || got.busy !== want.busy ||
                got.code !== want.code || got.status !== want.status) begin
               $display("%0t: mismatch, expected line %b busy %b code %h status %0d",
                        $realtime, want.data_level, want.busy, want.code, want.status);
               $display("%0t:           actual   line %b busy %b code %h status %0d",
                        $realtime, got.data_level, got.busy, got.code, got.status);
               errors++;
            end
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         apply_key_item(key_item_type'({req_tuser, req_tdata[0], req_tdata[8:1],
                                        req_tdata[9], req_tdata[17:10]}), want);
         expected_line_q.push_back(want);
      end
   end

endmodule
